// ===== design/bsmv_pkg.sv =====
// Package for the 3x3 block sparse matrix-vector accumulate block.
// Holds shared types, operation and register codes, and sizing constants.
// No dependencies.
`default_nettype none

package bsmv_pkg;

  localparam int DIM               = 3;
  localparam int BLOCK_COLUMNS_DEF = 1024;
  localparam int ADDR_W_MAX        = 16;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ACC    = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_LAYOUT = 2'd0,
    CFG_ALPHA  = 2'd1,
    CFG_BETA   = 2'd2,
    CFG_ORIGIN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                   kind;
    logic [1:0]            part;
    logic [ADDR_W_MAX-1:0] addr;
    logic [31:0]           val_a;
    logic [31:0]           val_b;
    logic [31:0]           val_c;
  } q_entry_t;

  typedef struct packed {
    logic        layout_column;
    logic [31:0] alpha_scale;
    logic [31:0] beta_scale;
  } scale_cfg_t;

endpackage

`default_nettype wire

// ===== design/bsmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bsmv_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bsmv_front.sv =====
// Front end: accepts input words, drops ones that do nothing, resolves the
// block column address and queues the rest for the back end. Uses bsmv_pkg.
`default_nettype none

module bsmv_front import bsmv_pkg::*; #(
  parameter int BLOCK_COLUMNS = BLOCK_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [10:0] in_column_number,
  input  wire logic [1:0]  in_part,
  input  wire logic [31:0] in_value_a,
  input  wire logic [31:0] in_value_b,
  input  wire logic [31:0] in_value_c,
  input  wire logic        index_origin,
  input  wire logic        q_pop,
  output logic             q_valid,
  output q_entry_t         q_head
);

  logic [31:0] col_in;
  logic [31:0] col_acc;
  logic        part_ok;
  logic        keep;
  q_entry_t    ent;
  logic        push;

  q_entry_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign col_in  = {21'b0, in_column_number};
  assign col_acc = col_in - {31'b0, index_origin};
  assign part_ok = (in_part < 2'(DIM));

  always_comb begin
    keep      = 1'b0;
    ent.kind  = op_t'(in_operation);
    ent.part  = in_part;
    ent.addr  = col_in[ADDR_W_MAX-1:0];
    ent.val_a = in_value_a;
    ent.val_b = in_value_b;
    ent.val_c = in_value_c;
    unique case (in_operation)
      OP_LOAD: begin
        keep = part_ok && (col_in < 32'(BLOCK_COLUMNS));
      end
      OP_ACC: begin
        keep     = part_ok && (col_in >= {31'b0, index_origin})
                   && (col_acc < 32'(BLOCK_COLUMNS));
        ent.addr = col_acc[ADDR_W_MAX-1:0];
      end
      OP_FINISH: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // queue
  assign in_stall = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count_r != '0);
  assign q_head   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= ent;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count over depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ===== design/bsmv_back.sv =====
// Back end: issues queued words to the x store, accumulates block products
// into three row sums and scales them into results. Uses bsmv_pkg, bsmv_ram.
`default_nettype none

module bsmv_back import bsmv_pkg::*; #(
  parameter int BLOCK_COLUMNS = BLOCK_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  q_entry_t         q_head,
  output logic             q_pop,
  input  scale_cfg_t       scale_cfg,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_y_row0,
  output logic [31:0]      out_y_row1,
  output logic [31:0]      out_y_row2
);

  localparam int AW = (BLOCK_COLUMNS > 1) ? $clog2(BLOCK_COLUMNS) : 1;

  logic adv;
  logic issue;

  logic [7:0] x_rdata [DIM];

  logic     s1_valid_r, s1_valid_nxt;
  q_entry_t s1_ent_r;
  logic     s1_fin;

  logic [31:0]        s1_val [DIM];
  logic signed [7:0]  v8 [DIM];
  logic signed [7:0]  xp;
  logic signed [15:0] prod_col [DIM];
  logic signed [15:0] prod_row [DIM];
  logic [31:0]        dot;

  logic [31:0] sum_r [DIM];
  logic [31:0] sum_nxt [DIM];

  logic        s2_valid_r, s2_valid_nxt;
  logic [31:0] pa_r [DIM];
  logic [31:0] pb_r [DIM];

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_y_r [DIM];

  assign adv   = !out_valid_r || !out_stall;
  assign issue = q_valid && adv;
  assign q_pop = issue;

  // x store, one RAM per element of the triple
  for (genvar p = 0; p < DIM; p++) begin : g_xram
    bsmv_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_COLUMNS)
    ) u_xram (
      .clk   (clk),
      .we    (issue && (q_head.kind == OP_LOAD) && (q_head.part == 2'(p))),
      .waddr (q_head.addr[AW-1:0]),
      .wdata (q_head.val_a[7:0]),
      .re    (issue && (q_head.kind == OP_ACC)),
      .raddr (q_head.addr[AW-1:0]),
      .rdata (x_rdata[p])
    );
  end

  // stage 1: multiply-accumulate
  assign s1_val[0] = s1_ent_r.val_a;
  assign s1_val[1] = s1_ent_r.val_b;
  assign s1_val[2] = s1_ent_r.val_c;
  assign s1_fin    = s1_valid_r && (s1_ent_r.kind == OP_FINISH);

  always_comb begin
    xp = $signed(x_rdata[0]);
    for (int i = 0; i < DIM; i++) begin
      if (s1_ent_r.part == 2'(i)) begin
        xp = $signed(x_rdata[i]);
      end
    end
    dot = '0;
    for (int i = 0; i < DIM; i++) begin
      v8[i]       = $signed(s1_val[i][7:0]);
      prod_col[i] = v8[i] * xp;
      prod_row[i] = v8[i] * $signed(x_rdata[i]);
      dot         = dot + {{16{prod_row[i][15]}}, prod_row[i]};
    end
  end

  always_comb begin
    s1_valid_nxt = adv ? issue : s1_valid_r;
    s2_valid_nxt = adv ? s1_fin : s2_valid_r;
    out_valid_nxt = adv ? s2_valid_r : out_valid_r;
    for (int i = 0; i < DIM; i++) begin
      sum_nxt[i] = sum_r[i];
    end
    if (adv && s1_valid_r) begin
      unique case (s1_ent_r.kind)
        OP_ACC: begin
          for (int i = 0; i < DIM; i++) begin
            if (scale_cfg.layout_column) begin
              sum_nxt[i] = sum_r[i] + {{16{prod_col[i][15]}}, prod_col[i]};
            end else if (s1_ent_r.part == 2'(i)) begin
              sum_nxt[i] = sum_r[i] + dot;
            end
          end
        end
        OP_FINISH: begin
          for (int i = 0; i < DIM; i++) begin
            sum_nxt[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIM; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < DIM; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

  // payload registers: stage 1 word, stage 2 products, output sums
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ent_r <= q_head;
      for (int i = 0; i < DIM; i++) begin
        pa_r[i]    <= scale_cfg.alpha_scale * sum_r[i];
        pb_r[i]    <= scale_cfg.beta_scale * s1_val[i];
        out_y_r[i] <= pa_r[i] + pb_r[i];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_y_row0 = out_y_r[0];
  assign out_y_row1 = out_y_r[1];
  assign out_y_row2 = out_y_r[2];

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fin && adv) |=> ((sum_r[0] == '0) && (sum_r[1] == '0) && (sum_r[2] == '0)))
    else $error("row sums not cleared after finish");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !adv) |=> s2_valid_r)
    else $error("result lost while output stalled");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_y_row0)
                                    && $stable(out_y_row1) && $stable(out_y_row2)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== design/block3_sparse_matvec_accumulate_top.sv =====
// A finish word passes the queue, stage 1 and stage 2 before out_valid shows it.
// Throughput: one word per cycle while not stalled; each word takes one issue slot
// at the x store port. A load then an accumulate of the same column needs no gap.
// Reset (rst_n low, synchronous) clears queue, pipeline, row sums and registers
// to layout 0, alpha 1, beta 0, origin 0; the x store is not cleared.
`default_nettype none

module block3_sparse_matvec_accumulate_top import bsmv_pkg::*; #(
  parameter int BLOCK_COLUMNS = BLOCK_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [10:0] in_column_number,
  input  wire logic [1:0]  in_part,
  input  wire logic [31:0] in_value_a,
  input  wire logic [31:0] in_value_b,
  input  wire logic [31:0] in_value_c,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_y_row0,
  output logic [31:0]      out_y_row1,
  output logic [31:0]      out_y_row2,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic        layout_column_r;
  logic [31:0] alpha_scale_r;
  logic [31:0] beta_scale_r;
  logic        index_origin_r;

  logic       q_pop;
  logic       q_valid;
  q_entry_t   q_head;
  scale_cfg_t scale_cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_column_r <= 1'b0;
      alpha_scale_r   <= 32'd1;
      beta_scale_r    <= '0;
      index_origin_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LAYOUT: layout_column_r <= cfg_wdata[0];
        CFG_ALPHA:  alpha_scale_r   <= cfg_wdata;
        CFG_BETA:   beta_scale_r    <= cfg_wdata;
        CFG_ORIGIN: index_origin_r  <= cfg_wdata[0];
      endcase
    end
  end

  assign scale_cfg.layout_column = layout_column_r;
  assign scale_cfg.alpha_scale   = alpha_scale_r;
  assign scale_cfg.beta_scale    = beta_scale_r;

  bsmv_front #(
    .BLOCK_COLUMNS (BLOCK_COLUMNS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_column_number (in_column_number),
    .in_part          (in_part),
    .in_value_a       (in_value_a),
    .in_value_b       (in_value_b),
    .in_value_c       (in_value_c),
    .index_origin     (index_origin_r),
    .q_pop            (q_pop),
    .q_valid          (q_valid),
    .q_head           (q_head)
  );

  bsmv_back #(
    .BLOCK_COLUMNS (BLOCK_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .scale_cfg  (scale_cfg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_y_row0 (out_y_row0),
    .out_y_row1 (out_y_row1),
    .out_y_row2 (out_y_row2)
  );

endmodule

`default_nettype wire
